// ----- design/rde_pkg.sv -----
// shared types, constants and helpers for the raster draw engine
package rde_pkg;

    // frame store geometry
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int X_BITS     = $clog2(MAX_WIDTH);
    localparam int Y_BITS     = $clog2(MAX_HEIGHT);
    localparam int ADDR_BITS  = $clog2(DEPTH);

    // field widths
    localparam int CFG_BITS   = 9;
    localparam int CRD_BITS   = 18;

    typedef logic signed [CRD_BITS-1:0] t_crd;
    typedef logic [2:0]                 t_cmd_code;
    typedef logic                       t_cfg_idx;

    // command codes
    localparam t_cmd_code CMD_PIXEL   = 3'd0;
    localparam t_cmd_code CMD_LINE    = 3'd1;
    localparam t_cmd_code CMD_BOX     = 3'd2;
    localparam t_cmd_code CMD_DIAMOND = 3'd3;
    localparam t_cmd_code CMD_READ    = 3'd4;

    // configuration register indexes
    localparam t_cfg_idx CFG_WIDTH  = 1'b0;
    localparam t_cfg_idx CFG_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_COL,
        S_PIX,
        S_BLEND,
        S_RPIX,
        S_RDOUT,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic load;
        logic prep;
        logic col_load;
        logic col_next;
        logic adv_line;
        logic adv_row;
        logic wr_pix;
        logic wr_blend;
        logic rd_capture;
        logic out_load;
    } t_dp_ctl;

    // datapath to controller
    typedef struct packed {
        logic      clr_done;
        t_cmd_code cmd;
        logic      blend;
        logic      in_frame;
        logic      line_last;
        logic      row_last;
        logic      col_last;
        logic      col_empty;
        logic      xr_empty;
    } t_dp_sts;

    function automatic t_crd crd_abs(input t_crd v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic t_crd crd_min(input t_crd a, input t_crd b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_crd crd_max(input t_crd a, input t_crd b);
        return (a < b) ? b : a;
    endfunction

endpackage

// ----- design/rde_ctrl.sv -----
// sequencer for the raster draw engine: clear pass, shape walk, result hand-off
module rde_ctrl
    import rde_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_ctl o_ctl
);

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   fin_last;
    logic   fin_col;

    // end-of-pixel decisions shared by plain and blended writes
    always_comb begin
        if (i_sts.cmd == CMD_BOX || i_sts.cmd == CMD_DIAMOND) begin
            fin_last = i_sts.row_last && i_sts.col_last;
            fin_col  = i_sts.row_last && !i_sts.col_last;
        end else begin
            fin_last = i_sts.line_last;
            fin_col  = 1'b0;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_PREP;
            end
            S_PREP: begin
                unique case (i_sts.cmd) inside
                    CMD_PIXEL, CMD_LINE:   n_state = S_PIX;
                    CMD_BOX, CMD_DIAMOND:  n_state = S_COL;
                    CMD_READ:              n_state = S_RPIX;
                    default:               n_state = S_DONE;
                endcase
            end
            S_COL: begin
                if (i_sts.xr_empty) begin
                    n_state = S_DONE;
                end else if (i_sts.col_empty) begin
                    if (i_sts.col_last) n_state = S_DONE;
                end else begin
                    n_state = S_PIX;
                end
            end
            S_PIX: begin
                if (i_sts.in_frame && i_sts.blend) begin
                    n_state = S_BLEND;
                end else if (fin_last) begin
                    n_state = S_DONE;
                end else if (fin_col) begin
                    n_state = S_COL;
                end
            end
            S_BLEND: begin
                if (fin_last) begin
                    n_state = S_DONE;
                end else if (fin_col) begin
                    n_state = S_COL;
                end else begin
                    n_state = S_PIX;
                end
            end
            S_RPIX:  n_state = S_RDOUT;
            S_RDOUT: n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // datapath commands
    always_comb begin
        o_ctl      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: o_ctl.clr_step = 1'b1;
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.load = i_in_valid;
            end
            S_PREP: o_ctl.prep = 1'b1;
            S_COL: begin
                o_ctl.col_load = !i_sts.xr_empty && !i_sts.col_empty;
                o_ctl.col_next = !i_sts.xr_empty && i_sts.col_empty && !i_sts.col_last;
            end
            S_PIX: begin
                if (!(i_sts.in_frame && i_sts.blend)) begin
                    o_ctl.wr_pix   = i_sts.in_frame;
                    o_ctl.col_next = fin_col;
                    o_ctl.adv_line = !fin_last && !fin_col
                                     && !(i_sts.cmd == CMD_BOX || i_sts.cmd == CMD_DIAMOND);
                    o_ctl.adv_row  = !fin_last && !fin_col
                                     && (i_sts.cmd == CMD_BOX || i_sts.cmd == CMD_DIAMOND);
                end
            end
            S_BLEND: begin
                o_ctl.wr_blend = 1'b1;
                o_ctl.col_next = fin_col;
                o_ctl.adv_line = !fin_last && !fin_col
                                 && !(i_sts.cmd == CMD_BOX || i_sts.cmd == CMD_DIAMOND);
                o_ctl.adv_row  = !fin_last && !fin_col
                                 && (i_sts.cmd == CMD_BOX || i_sts.cmd == CMD_DIAMOND);
            end
            S_RPIX:  ;
            S_RDOUT: o_ctl.rd_capture = 1'b1;
            S_DONE:  o_ctl.out_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    // an accepted request always goes to setup next
    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_PREP))
        else $error("accepted request did not enter setup");

    // pixel writes to the frame store go only to pixels inside the frame
    a_wr_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.wr_pix || o_ctl.wr_blend) |-> i_sts.in_frame)
        else $error("pixel write outside the frame");

    // a result never overwrites one that is still waiting
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");

    // a new result only follows the completion state
    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside completion");

endmodule

// ----- design/rde_dp.sv -----
// datapath: shape walkers, clipping, blend unit, frame store and result registers
module rde_dp
    import rde_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_BITS-1:0]   i_cfg_data,
    input  t_cmd_code             i_cmd,
    input  logic signed [15:0]    i_x_start,
    input  logic signed [15:0]    i_y_start,
    input  logic signed [15:0]    i_x_end,
    input  logic signed [15:0]    i_y_end,
    input  logic [15:0]           i_diamond_size,
    input  logic [7:0]            i_red,
    input  logic [7:0]            i_green,
    input  logic [7:0]            i_blue,
    input  logic                  i_blend,
    input  t_dp_ctl               i_ctl,
    output t_dp_sts               o_sts,
    output logic [7:0]            o_read_red,
    output logic [7:0]            o_read_green,
    output logic [7:0]            o_read_blue,
    output logic                  o_inside_res
);

    // configuration
    logic [CFG_BITS-1:0] r_fw, r_fh;
    t_crd                w_lim, h_lim;

    // captured request
    t_cmd_code           r_cmd;
    logic signed [15:0]  r_xs, r_ys, r_xe, r_ye;
    logic [14:0]         r_hw;
    logic [23:0]         r_color;
    logic                r_blend;

    // line walker
    logic [15:0]         r_t, r_q, r_r, r_d, r_m;
    logic                r_xmaj, r_smaj, r_smin;
    t_crd                r_bmaj, r_bmin;

    // area walker
    t_crd                r_ax, r_xhi, r_ay, r_yhi, r_byl, r_byh;

    // frame store
    logic [23:0]          r_mem [DEPTH];
    logic [23:0]          r_rdata;
    logic [ADDR_BITS-1:0] r_clr;

    // results
    logic [23:0]         r_res_rgb, r_out_rgb;
    logic                r_res_in, r_out_in;

    t_crd                dx, dy, adx, ady;
    t_crd                p_xmin, p_xmax, p_ylo, p_yhi;
    t_crd                c_dist, c_a, c_yl, c_yh;
    logic                rnd_up;
    logic [16:0]         qq, rsum;
    t_crd                cur_maj, cur_min, cur_x, cur_y;
    logic                in_frame, is_area;
    logic [ADDR_BITS-1:0] addr, wr_addr;
    logic [23:0]         wr_data, blend_rgb;
    logic                mem_we;

    // effective frame limits
    always_comb begin
        w_lim = ((r_fw > CFG_BITS'(MAX_WIDTH)) ? t_crd'(MAX_WIDTH) : t_crd'({1'b0, r_fw}))
                - t_crd'(1);
        h_lim = ((r_fh > CFG_BITS'(MAX_HEIGHT)) ? t_crd'(MAX_HEIGHT) : t_crd'({1'b0, r_fh}))
                - t_crd'(1);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= CFG_BITS'(256);
            r_fh <= CFG_BITS'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:  r_fw <= i_cfg_data;
                CFG_HEIGHT: r_fh <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    assign is_area = (r_cmd == CMD_BOX) || (r_cmd == CMD_DIAMOND);

    // request capture; pixel and read use a zero-length line
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= i_cmd;
            r_xs    <= i_x_start;
            r_ys    <= i_y_start;
            r_hw    <= i_diamond_size[15:1];
            r_color <= {i_red, i_green, i_blue};
            r_blend <= i_blend;
            if (i_cmd == CMD_LINE || i_cmd == CMD_BOX) begin
                r_xe <= i_x_end;
                r_ye <= i_y_end;
            end else begin
                r_xe <= i_x_start;
                r_ye <= i_y_start;
            end
        end
    end

    // setup arithmetic
    always_comb begin
        dx  = t_crd'(r_xe) - t_crd'(r_xs);
        dy  = t_crd'(r_ye) - t_crd'(r_ys);
        adx = crd_abs(dx);
        ady = crd_abs(dy);
        if (r_cmd == CMD_DIAMOND) begin
            p_xmin = t_crd'(r_xs) - t_crd'({1'b0, r_hw});
            p_xmax = t_crd'(r_xs) + t_crd'({1'b0, r_hw});
        end else begin
            p_xmin = crd_min(t_crd'(r_xs), t_crd'(r_xe));
            p_xmax = crd_max(t_crd'(r_xs), t_crd'(r_xe));
        end
        p_ylo = crd_max(crd_min(t_crd'(r_ys), t_crd'(r_ye)), t_crd'(0));
        p_yhi = crd_min(crd_max(t_crd'(r_ys), t_crd'(r_ye)), h_lim);
    end

    // column bounds for the area walker
    always_comb begin
        c_dist = crd_abs(r_ax - t_crd'(r_xs));
        c_a    = t_crd'({1'b0, r_hw}) - c_dist;
        if (r_cmd == CMD_DIAMOND) begin
            c_yl = crd_max(t_crd'(r_ys) - c_a, t_crd'(0));
            c_yh = crd_min(t_crd'(r_ys) + c_a, h_lim);
        end else begin
            c_yl = r_byl;
            c_yh = r_byh;
        end
    end

    // line walker: minor offset rounded to nearest, ties to even
    always_comb begin
        rnd_up  = ({r_r, 1'b0} > {1'b0, r_d}) || (({r_r, 1'b0} == {1'b0, r_d}) && r_q[0]);
        qq      = {1'b0, r_q} + {16'd0, rnd_up};
        rsum    = {1'b0, r_r} + {1'b0, r_m};
        cur_maj = r_smaj ? r_bmaj - t_crd'({2'b00, r_t}) : r_bmaj + t_crd'({2'b00, r_t});
        cur_min = r_smin ? r_bmin - t_crd'({1'b0, qq})   : r_bmin + t_crd'({1'b0, qq});
    end

    // line and area walker registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.prep) begin
            r_t    <= '0;
            r_q    <= '0;
            r_r    <= '0;
            r_xmaj <= adx > ady;
            if (adx > ady) begin
                r_d    <= adx[15:0];
                r_m    <= ady[15:0];
                r_smaj <= dx < 0;
                r_smin <= dy < 0;
                r_bmaj <= t_crd'(r_xs);
                r_bmin <= t_crd'(r_ys);
            end else begin
                r_d    <= ady[15:0];
                r_m    <= adx[15:0];
                r_smaj <= dy < 0;
                r_smin <= dx < 0;
                r_bmaj <= t_crd'(r_ys);
                r_bmin <= t_crd'(r_xs);
            end
            r_ax  <= crd_max(p_xmin, t_crd'(0));
            r_xhi <= crd_min(p_xmax, w_lim);
            r_byl <= p_ylo;
            r_byh <= p_yhi;
        end else begin
            if (i_ctl.adv_line) begin
                r_t <= r_t + 16'd1;
                if (rsum >= {1'b0, r_d}) begin
                    r_r <= 16'(rsum - {1'b0, r_d});
                    r_q <= r_q + 16'd1;
                end else begin
                    r_r <= rsum[15:0];
                end
            end
            if (i_ctl.col_load) begin
                r_ay  <= c_yl;
                r_yhi <= c_yh;
            end
            if (i_ctl.adv_row) r_ay <= r_ay + t_crd'(1);
            if (i_ctl.col_next) r_ax <= r_ax + t_crd'(1);
        end
    end

    // current pixel and clipping
    always_comb begin
        if (is_area) begin
            cur_x = r_ax;
            cur_y = r_ay;
        end else if (r_xmaj) begin
            cur_x = cur_maj;
            cur_y = cur_min;
        end else begin
            cur_x = cur_min;
            cur_y = cur_maj;
        end
        in_frame = (cur_x >= 0) && (cur_y >= 0) && (cur_x <= w_lim) && (cur_y <= h_lim);
        addr     = ADDR_BITS'(ADDR_BITS'(cur_y[Y_BITS-1:0]) * ADDR_BITS'(MAX_WIDTH)
                   + ADDR_BITS'(cur_x[X_BITS-1:0]));
    end

    // additive blend with spill
    always_comb begin
        logic [8:0]  s0, s1, s2;
        logic [9:0]  ex;
        logic [9:0]  t0, t1, t2;
        s0 = {1'b0, r_rdata[23:16]} + {1'b0, r_color[23:16]};
        s1 = {1'b0, r_rdata[15:8]}  + {1'b0, r_color[15:8]};
        s2 = {1'b0, r_rdata[7:0]}   + {1'b0, r_color[7:0]};
        ex = ((s0 > 9'd255) ? 10'(s0 - 9'd255) : 10'd0)
           + ((s1 > 9'd255) ? 10'(s1 - 9'd255) : 10'd0)
           + ((s2 > 9'd255) ? 10'(s2 - 9'd255) : 10'd0);
        t0 = {1'b0, s0} + {4'd0, ex[9:4]};
        t1 = {1'b0, s1} + {4'd0, ex[9:4]};
        t2 = {1'b0, s2} + {4'd0, ex[9:4]};
        blend_rgb = {(t0 > 10'd255) ? 8'd255 : t0[7:0],
                     (t1 > 10'd255) ? 8'd255 : t1[7:0],
                     (t2 > 10'd255) ? 8'd255 : t2[7:0]};
    end

    // write port select
    always_comb begin
        mem_we  = i_ctl.clr_step || i_ctl.wr_pix || i_ctl.wr_blend;
        wr_addr = i_ctl.clr_step ? r_clr : addr;
        if (i_ctl.clr_step) begin
            wr_data = '0;
        end else if (i_ctl.wr_blend) begin
            wr_data = blend_rgb;
        end else begin
            wr_data = r_color;
        end
    end

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_ctl.clr_step) begin
            r_clr <= r_clr + ADDR_BITS'(1);
        end
    end

    // frame store
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[wr_addr] <= wr_data;
        r_rdata <= r_mem[addr];
    end

    // read result staging and output registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_res_rgb <= '0;
            r_res_in  <= 1'b0;
        end else if (i_ctl.rd_capture) begin
            r_res_rgb <= in_frame ? r_rdata : 24'd0;
            r_res_in  <= in_frame;
        end
        if (i_ctl.out_load) begin
            r_out_rgb <= r_res_rgb;
            r_out_in  <= r_res_in;
        end
    end

    assign o_read_red   = r_out_rgb[23:16];
    assign o_read_green = r_out_rgb[15:8];
    assign o_read_blue  = r_out_rgb[7:0];
    assign o_inside_res = r_out_in;

    // status to the sequencer
    always_comb begin
        o_sts.clr_done  = r_clr == ADDR_BITS'(DEPTH - 1);
        o_sts.cmd       = r_cmd;
        o_sts.blend     = r_blend;
        o_sts.in_frame  = in_frame;
        o_sts.line_last = r_t == r_d;
        o_sts.row_last  = r_ay == r_yhi;
        o_sts.col_last  = r_ax == r_xhi;
        o_sts.col_empty = c_yl > c_yh;
        o_sts.xr_empty  = r_ax > r_xhi;
    end

endmodule

// ----- design/raster_draw_engine.sv -----
// top level of the raster draw engine
// Draws pixels, lines, filled boxes and filled diamonds into a 256 x 256 frame store of
// 24-bit RGB and reads single pixels back; every request returns exactly one result.
// After reset the store is cleared one entry per cycle, 65536 entries, during which no
// request is taken (configuration writes still are). A request passes through setup,
// visits its pixels and then hands off its result; a blended pixel inside the frame takes
// an extra blend step, as the store read is registered and the old value must arrive
// before the sum is written. A line visits max(|dx|,|dy|)+1 pixels, clipped or not;
// box and diamond visit only the pixels of the clipped area plus a column step per column.
// A finished result waits in an output register while the next request is worked on.
module raster_draw_engine
    import rde_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  t_cfg_idx            i_cfg_idx,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [2:0]          i_cmd,
    input  logic signed [15:0]  i_x_start,
    input  logic signed [15:0]  i_y_start,
    input  logic signed [15:0]  i_x_end,
    input  logic signed [15:0]  i_y_end,
    input  logic [15:0]         i_diamond_size,
    input  logic [7:0]          i_red,
    input  logic [7:0]          i_green,
    input  logic [7:0]          i_blue,
    input  logic                i_blend,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_read_red,
    output logic [7:0]          o_read_green,
    output logic [7:0]          o_read_blue,
    output logic                o_inside_res
);

    t_dp_ctl ctl;
    t_dp_sts sts;

    // sequencer
    rde_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    // datapath and frame store
    rde_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (i_cmd),
        .i_x_start      (i_x_start),
        .i_y_start      (i_y_start),
        .i_x_end        (i_x_end),
        .i_y_end        (i_y_end),
        .i_diamond_size (i_diamond_size),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_blend        (i_blend),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .o_read_red     (o_read_red),
        .o_read_green   (o_read_green),
        .o_read_blue    (o_read_blue),
        .o_inside_res   (o_inside_res)
    );

endmodule

// ----- test/rde_checker.sv -----
// request and result monitor with a frame store predictor for the raster draw engine
module rde_checker
    import rde_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  t_cfg_idx            i_cfg_idx,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [2:0]          i_cmd,
    input  logic signed [15:0]  i_x_start,
    input  logic signed [15:0]  i_y_start,
    input  logic signed [15:0]  i_x_end,
    input  logic signed [15:0]  i_y_end,
    input  logic [15:0]         i_diamond_size,
    input  logic [7:0]          i_red,
    input  logic [7:0]          i_green,
    input  logic [7:0]          i_blue,
    input  logic                i_blend,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [7:0]          i_read_red,
    input  logic [7:0]          i_read_green,
    input  logic [7:0]          i_read_blue,
    input  logic                i_inside_res,
    output int                  o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       in_frame;
    } pix_result_t;

    logic [23:0]         shadow_frame [DEPTH];
    logic [CFG_BITS-1:0] shadow_w;
    logic [CFG_BITS-1:0] shadow_h;
    pix_result_t         pending_reads [$];
    bit                  frame_cleared;
    int                  err_cnt;

    assign o_errors = err_cnt;

    task automatic report_err(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_cnt++;
    endtask

    function automatic longint clip_w();
        return (shadow_w < MAX_WIDTH) ? longint'(shadow_w) : longint'(MAX_WIDTH);
    endfunction

    function automatic longint clip_h();
        return (shadow_h < MAX_HEIGHT) ? longint'(shadow_h) : longint'(MAX_HEIGHT);
    endfunction

    // write one pixel, overwrite or additive with spill
    function automatic void put_pixel(input longint x, input longint y,
                                      input logic [23:0] color, input bit mix);
        int unsigned addr;
        int          sum [3];
        int          spill;
        logic [23:0] prev;
        if (x < 0 || y < 0 || x >= clip_w() || y >= clip_h())
            return;
        addr = int'(y) * MAX_WIDTH + int'(x);
        if (!mix) begin
            shadow_frame[addr] = color;
            return;
        end
        prev   = shadow_frame[addr];
        sum[0] = prev[23:16] + color[23:16];
        sum[1] = prev[15:8] + color[15:8];
        sum[2] = prev[7:0] + color[7:0];
        spill  = 0;
        for (int c = 0; c < 3; c++)
            if (sum[c] > 255) spill += sum[c] - 255;
        spill /= 16;
        for (int c = 0; c < 3; c++) begin
            sum[c] += spill;
            if (sum[c] > 255) sum[c] = 255;
        end
        shadow_frame[addr] = {sum[0][7:0], sum[1][7:0], sum[2][7:0]};
    endfunction

    // n/d rounded to nearest, ties to even
    function automatic longint round_ratio(input longint n, input longint d);
        longint q;
        longint r;
        if (d < 0) begin
            d = -d;
            n = -n;
        end
        q = n / d;
        r = n % d;
        if (r < 0) begin
            q -= 1;
            r += d;
        end
        if (2 * r > d || (2 * r == d && q[0]))
            q += 1;
        return q;
    endfunction

    function automatic void trace_line(input longint x0, input longint y0, input longint x1,
                                       input longint y1, input logic [23:0] color,
                                       input bit mix);
        longint dx;
        longint dy;
        longint sx;
        longint sy;
        dx = x1 - x0;
        dy = y1 - y0;
        sx = (dx > 0) ? 1 : -1;
        sy = (dy > 0) ? 1 : -1;
        if (dx == 0 || dy == 0) begin
            if (dx != 0)
                for (longint k = 0; k != dx; k += sx) put_pixel(x0 + k, y0, color, mix);
            else if (dy != 0)
                for (longint k = 0; k != dy; k += sy) put_pixel(x0, y0 + k, color, mix);
            put_pixel(x1, y1, color, mix);
            return;
        end
        put_pixel(x0, y0, color, mix);
        put_pixel(x1, y1, color, mix);
        if ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy)) begin
            for (longint k = sx; k != dx; k += sx)
                put_pixel(x0 + k, y0 + round_ratio(k * dy, dx), color, mix);
        end else begin
            for (longint k = sy; k != dy; k += sy)
                put_pixel(x0 + round_ratio(k * dx, dy), y0 + k, color, mix);
        end
    endfunction

    function automatic void fill_box(input longint x0, input longint y0, input longint x1,
                                     input longint y1, input logic [23:0] color,
                                     input bit mix);
        longint xl;
        longint xh;
        longint yl;
        longint yh;
        xl = (x0 < x1) ? x0 : x1;
        xh = (x0 < x1) ? x1 : x0;
        yl = (y0 < y1) ? y0 : y1;
        yh = (y0 < y1) ? y1 : y0;
        if (xl < 0) xl = 0;
        if (yl < 0) yl = 0;
        if (xh > clip_w() - 1) xh = clip_w() - 1;
        if (yh > clip_h() - 1) yh = clip_h() - 1;
        for (longint x = xl; x <= xh; x++)
            for (longint y = yl; y <= yh; y++)
                put_pixel(x, y, color, mix);
    endfunction

    function automatic void fill_diamond(input longint cx, input longint cy, input longint hw,
                                         input logic [23:0] color, input bit mix);
        longint xl;
        longint xh;
        longint span;
        longint yl;
        longint yh;
        xl = cx - hw;
        xh = cx + hw;
        if (xl < 0) xl = 0;
        if (xh > clip_w() - 1) xh = clip_w() - 1;
        for (longint x = xl; x <= xh; x++) begin
            span = hw - ((x - cx) < 0 ? cx - x : x - cx);
            yl   = cy - span;
            yh   = cy + span;
            if (yl < 0) yl = 0;
            if (yh > clip_h() - 1) yh = clip_h() - 1;
            for (longint y = yl; y <= yh; y++)
                put_pixel(x, y, color, mix);
        end
    endfunction

    // apply one request to the shadow frame and return its expected result
    function automatic pix_result_t apply_request();
        pix_result_t res;
        logic [23:0] color;
        longint      xs;
        longint      ys;
        res   = '0;
        color = {i_red, i_green, i_blue};
        xs    = longint'(i_x_start);
        ys    = longint'(i_y_start);
        case (i_cmd)
            CMD_PIXEL:   put_pixel(xs, ys, color, i_blend);
            CMD_LINE:    trace_line(xs, ys, longint'(i_x_end), longint'(i_y_end), color,
                                    i_blend);
            CMD_BOX:     fill_box(xs, ys, longint'(i_x_end), longint'(i_y_end), color,
                                  i_blend);
            CMD_DIAMOND: fill_diamond(xs, ys, longint'(i_diamond_size >> 1), color, i_blend);
            CMD_READ: begin
                if (xs >= 0 && ys >= 0 && xs < clip_w() && ys < clip_h()) begin
                    {res.red, res.green, res.blue} =
                        shadow_frame[int'(ys) * MAX_WIDTH + int'(xs)];
                    res.in_frame = 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // watch configuration, requests and results
    always @(posedge i_clk) begin
        pix_result_t want;
        if (!i_rst_n) begin
            shadow_w <= CFG_BITS'(MAX_WIDTH);
            shadow_h <= CFG_BITS'(MAX_HEIGHT);
            if (!frame_cleared) begin
                for (int a = 0; a < DEPTH; a++) shadow_frame[a] = '0;
                frame_cleared = 1'b1;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WIDTH) shadow_w <= i_cfg_data;
                else shadow_h <= i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_reads.size() == 0) begin
                    report_err("result with no request outstanding");
                end else begin
                    want = pending_reads.pop_front();
                    if (i_read_red !== want.red)
                        report_err($sformatf("red %0h, want %0h", i_read_red, want.red));
                    if (i_read_green !== want.green)
                        report_err($sformatf("green %0h, want %0h", i_read_green,
                                             want.green));
                    if (i_read_blue !== want.blue)
                        report_err($sformatf("blue %0h, want %0h", i_read_blue, want.blue));
                    if (i_inside_res !== want.in_frame)
                        report_err($sformatf("inside %b, want %b", i_inside_res,
                                             want.in_frame));
                end
            end
            if (i_in_valid && i_in_ready)
                pending_reads.push_back(apply_request());
        end
    end

    // leftover expectations are checked by the top once traffic has drained
    final begin
        if (pending_reads.size() != 0)
            $display("results still outstanding: %0d", pending_reads.size());
    end

endmodule

// ----- test/testbench.sv -----
// stimulus, handshake pacing and verdict for the raster draw engine
module testbench;
    import rde_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 1000000;
    localparam int PHASES      = 6;
    localparam int PHASE_REQS  = 215;

    typedef struct {
        t_cmd_code          cmd;
        logic signed [15:0] xs;
        logic signed [15:0] ys;
        logic signed [15:0] xe;
        logic signed [15:0] ye;
        logic [15:0]        size;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               blend;
    } draw_req_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    t_cfg_idx            i_cfg_idx;
    logic [CFG_BITS-1:0] i_cfg_data;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [2:0]          i_cmd;
    logic signed [15:0]  i_x_start;
    logic signed [15:0]  i_y_start;
    logic signed [15:0]  i_x_end;
    logic signed [15:0]  i_y_end;
    logic [15:0]         i_diamond_size;
    logic [7:0]          i_red;
    logic [7:0]          i_green;
    logic [7:0]          i_blue;
    logic                i_blend;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [7:0]          o_read_red;
    logic [7:0]          o_read_green;
    logic [7:0]          o_read_blue;
    logic                o_inside_res;

    int          err_total;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          req_cnt;
    int          res_cnt;
    int          stall_cnt;
    int          read_cnt;
    logic [15:0] last_x;
    logic [15:0] last_y;

    always #2 i_clk = ~i_clk;

    raster_draw_engine i_dut (.*);

    rde_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_x_start      (i_x_start),
        .i_y_start      (i_y_start),
        .i_x_end        (i_x_end),
        .i_y_end        (i_y_end),
        .i_diamond_size (i_diamond_size),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_blend        (i_blend),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_read_red     (o_read_red),
        .i_read_green   (o_read_green),
        .i_read_blue    (o_read_blue),
        .i_inside_res   (o_inside_res),
        .o_errors       (err_total)
    );

    // result side back-pressure
    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(99) >= rx_idle_pct);

    // handshake counters and no-progress watchdog
    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) req_cnt <= req_cnt + 1;
        if (o_out_valid && i_out_ready) res_cnt <= res_cnt + 1;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", stall_cnt);
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    function automatic draw_req_t mk(input t_cmd_code cmd, input int xs, input int ys,
                                     input int xe, input int ye, input int size,
                                     input logic [23:0] color, input bit blend);
        draw_req_t q;
        q.cmd   = cmd;
        q.xs    = 16'(xs);
        q.ys    = 16'(ys);
        q.xe    = 16'(xe);
        q.ye    = 16'(ye);
        q.size  = 16'(size);
        {q.red, q.green, q.blue} = color;
        q.blend = blend;
        return q;
    endfunction

    // coordinate mostly around the frame, sometimes anywhere
    function automatic int near_crd();
        if ($urandom_range(99) < 5) return int'($signed(16'($urandom)));
        return int'($urandom_range(0, 275)) - 10;
    endfunction

    function automatic int offset_crd(input int base, input int reach);
        if ($urandom_range(99) < 2) return int'($signed(16'($urandom)));
        return base + int'($urandom_range(0, 2 * reach)) - reach;
    endfunction

    // counters are updated on the clock edge of a handshake, so always look after the next edge
    task automatic wait_drained();
        do @(posedge i_clk); while (res_cnt != req_cnt);
    endtask

    // send one request, with a random gap before it
    task automatic push(input draw_req_t q);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_cmd          <= q.cmd;
        i_x_start      <= q.xs;
        i_y_start      <= q.ys;
        i_x_end        <= q.xe;
        i_y_end        <= q.ye;
        i_diamond_size <= q.size;
        i_red          <= q.red;
        i_green        <= q.green;
        i_blue         <= q.blue;
        i_blend        <= q.blend;
        if (q.cmd == CMD_READ) read_cnt++;
        else begin
            last_x = q.xs;
            last_y = q.ys;
        end
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // frame size change while the engine is idle
    task automatic set_frame(input int w, input int h);
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_WIDTH;
        i_cfg_data <= CFG_BITS'(w);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_HEIGHT;
        i_cfg_data <= CFG_BITS'(h);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic draw_req_t random_req();
        draw_req_t q;
        int        pick;
        int        x;
        int        y;
        pick = $urandom_range(99);
        x    = near_crd();
        y    = near_crd();
        q    = mk(CMD_PIXEL, x, y, int'($urandom), int'($urandom), $urandom,
                  24'($urandom), $urandom_range(1));
        if (pick < 25) begin
            q.cmd = CMD_PIXEL;
        end else if (pick < 45) begin
            q.cmd = CMD_LINE;
            q.xe  = 16'(offset_crd(x, 30));
            q.ye  = 16'(offset_crd(y, 30));
        end else if (pick < 60) begin
            q.cmd = CMD_BOX;
            if ($urandom_range(99) == 0) begin
                q.xe = 16'($urandom);
                q.ye = 16'($urandom);
            end else begin
                q.xe = 16'(x + int'($urandom_range(0, 40)) - 20);
                q.ye = 16'(y + int'($urandom_range(0, 40)) - 20);
            end
        end else if (pick < 72) begin
            q.cmd = CMD_DIAMOND;
            if ($urandom_range(99) >= 2) q.size = 16'($urandom_range(0, 40));
        end else if (pick < 97) begin
            q.cmd = CMD_READ;
            if ($urandom_range(99) < 40) begin
                q.xs = 16'(int'($signed(last_x)) + int'($urandom_range(0, 4)) - 2);
                q.ys = 16'(int'($signed(last_y)) + int'($urandom_range(0, 4)) - 2);
            end
        end else begin
            q.cmd = t_cmd_code'($urandom_range(5, 7));
        end
        return q;
    endfunction

    initial begin
        int phase_w [PHASES] = '{256, 511, 0, 1, 37, 256};
        int phase_h [PHASES] = '{256, 300, 100, 1, 200, 17};
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_WIDTH;
        i_cfg_data     <= '0;
        i_in_valid     <= 1'b0;
        i_cmd          <= CMD_PIXEL;
        i_x_start      <= '0;
        i_y_start      <= '0;
        i_x_end        <= '0;
        i_y_end        <= '0;
        i_diamond_size <= '0;
        i_red          <= '0;
        i_green        <= '0;
        i_blue         <= '0;
        i_blend        <= 1'b0;
        i_out_ready    <= 1'b0;
        req_cnt        = 0;
        res_cnt        = 0;
        stall_cnt      = 0;
        read_cnt       = 0;
        last_x         = '0;
        last_y         = '0;
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: corners, clipping, blending spill, line rounding, shape extremes
        push(mk(CMD_PIXEL, 0, 0, 0, 0, 0, 24'hff_ff_ff, 0));
        push(mk(CMD_PIXEL, 255, 255, 0, 0, 0, 24'h12_34_56, 0));
        push(mk(CMD_PIXEL, -1, 5, 0, 0, 0, 24'hff_00_00, 0));
        push(mk(CMD_PIXEL, 32767, -32768, -1, -1, 65535, 24'h00_ff_00, 1));
        push(mk(CMD_PIXEL, 0, 0, 0, 0, 0, 24'hc8_c8_10, 1));
        push(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
        push(mk(CMD_READ, 255, 255, 0, 0, 0, 0, 0));
        push(mk(CMD_READ, -1, 0, 0, 0, 0, 0, 0));
        push(mk(CMD_READ, 300, 3, 0, 0, 0, 0, 0));
        push(mk(CMD_LINE, 10, 20, 30, 20, 0, 24'h01_02_03, 0));
        push(mk(CMD_LINE, 40, 50, 40, 10, 0, 24'h04_05_06, 1));
        push(mk(CMD_LINE, 7, 7, 7, 7, 0, 24'h07_08_09, 0));
        push(mk(CMD_LINE, 100, 100, 90, 90, 0, 24'h0a_0b_0c, 0));
        push(mk(CMD_LINE, 50, 60, 54, 62, 0, 24'h0d_0e_0f, 0));
        push(mk(CMD_LINE, 60, 50, 57, 58, 0, 24'h10_11_12, 1));
        push(mk(CMD_READ, 51, 60, 0, 0, 0, 0, 0));
        push(mk(CMD_LINE, -32768, -32768, 32767, 32767, 0, 24'h80_40_20, 0));
        push(mk(CMD_BOX, 20, 30, 5, 12, 0, 24'h33_44_55, 0));
        push(mk(CMD_BOX, -5, -5, 300, 300, 0, 24'hf0_f0_f0, 1));
        push(mk(CMD_DIAMOND, 128, 128, 0, 0, 0, 24'h99_99_99, 0));
        push(mk(CMD_DIAMOND, 3, 4, 0, 0, 1, 24'h55_66_77, 0));
        push(mk(CMD_DIAMOND, 250, 2, 0, 0, 12, 24'h20_30_40, 1));
        push(mk(CMD_DIAMOND, -32768, -32768, 0, 0, 65535, 24'hff_ff_ff, 0));
        push(mk(t_cmd_code'(5), 1, 1, 1, 1, 1, 24'hff_ff_ff, 1));
        push(mk(t_cmd_code'(7), 1, 1, 1, 1, 1, 24'hff_ff_ff, 0));

        // random phases across frame sizes and pacing patterns
        for (int ph = 0; ph < PHASES; ph++) begin
            set_frame(phase_w[ph], phase_h[ph]);
            tx_idle_pct = (ph < 2) ? 35 : (ph < 4) ? 76 : 0;
            rx_idle_pct = (ph < 2) ? 76 : (ph < 4) ? 35 : 0;
            for (int n = 0; n < PHASE_REQS; n++) begin
                if ($urandom_range(99) == 0) begin
                    i_in_valid <= 1'b0;
                    wait_drained();
                end
                push(random_req());
            end
        end

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (50) @(posedge i_clk);
        $display("%0d requests sent (%0d pixel reads), %0d results checked", req_cnt,
                 read_cnt, res_cnt);
        $display("six frame sizes, overwrite and blend, with and without back-pressure");
        if (err_total == 0 && res_cnt == req_cnt) begin
            $display("DONE: 0 errors");
        end else begin
            if (res_cnt != req_cnt)
                $display("%0d results never arrived", req_cnt - res_cnt);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/rde_pkg.sv
design/rde_ctrl.sv
design/rde_dp.sv
design/raster_draw_engine.sv
test/rde_checker.sv
test/testbench.sv
